// File: rtl/mlcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlcc_pkg;

   localparam int StateWidth = 4;
   localparam int KindWidth  = 3;
   localparam int AddrWidth  = 32;
   localparam int NodeWidth  = 4;

   // line states
   localparam logic [StateWidth-1:0] ST_I  = 4'd0;
   localparam logic [StateWidth-1:0] ST_S  = 4'd1;
   localparam logic [StateWidth-1:0] ST_E  = 4'd2;
   localparam logic [StateWidth-1:0] ST_O  = 4'd3;
   localparam logic [StateWidth-1:0] ST_M  = 4'd4;
   localparam logic [StateWidth-1:0] ST_F  = 4'd5;
   localparam logic [StateWidth-1:0] ST_IS = 4'd6;
   localparam logic [StateWidth-1:0] ST_IM = 4'd7;
   localparam logic [StateWidth-1:0] ST_MS = 4'd8;
   localparam logic [StateWidth-1:0] ST_OM = 4'd9;
   localparam logic [StateWidth-1:0] ST_FM = 4'd10;

   // event kinds
   localparam logic [KindWidth-1:0] EV_LOAD  = 3'd0;
   localparam logic [KindWidth-1:0] EV_STORE = 3'd1;
   localparam logic [KindWidth-1:0] EV_GETS  = 3'd2;
   localparam logic [KindWidth-1:0] EV_GETM  = 3'd3;
   localparam logic [KindWidth-1:0] EV_DATA  = 3'd4;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [AddrWidth-1:0] line_addr;
      logic [NodeWidth-1:0] source_node;
      logic                 shared_in;
   } req_word_type;

   typedef struct packed {
      logic                  issue_gets;
      logic                  issue_getm;
      logic                  data_to_cpu;
      logic                  data_to_bus;
      logic [NodeWidth-1:0]  data_dest;
      logic [AddrWidth-1:0]  out_addr;
      logic                  assert_shared;
      logic                  miss_pulse;
      logic                  upgrade_pulse;
      logic                  protocol_error;
      logic [StateWidth-1:0] new_state;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: rtl/mlcc_next_state.sv
`timescale 1ns / 1ps
`default_nettype none

module mlcc_next_state
   import mlcc_pkg::*;
(
   input  wire logic [StateWidth-1:0] cur_state,
   input  wire logic [NodeWidth-1:0]  own_node_id,
   input  wire req_word_type          req,
   output rsp_word_type               rsp
);

   always_comb begin
      logic [StateWidth-1:0] ns;
      logic gets, getm, tocpu, tobus, shr, miss, upg, err, other;

      ns    = cur_state;
      gets  = 1'b0;
      getm  = 1'b0;
      tocpu = 1'b0;
      tobus = 1'b0;
      shr   = 1'b0;
      miss  = 1'b0;
      upg   = 1'b0;
      err   = 1'b0;
      other = (req.source_node != own_node_id);

      if (req.kind > EV_DATA || cur_state > ST_FM) begin
         err = 1'b1;
      end else begin
         case (req.kind)
            EV_LOAD: begin
               case (cur_state)
                  ST_I: begin
                     gets = 1'b1;
                     miss = 1'b1;
                     ns   = ST_IS;
                  end
                  ST_S, ST_O, ST_M, ST_E, ST_F: tocpu = 1'b1;
                  default: ;
               endcase
            end
            EV_STORE: begin
               case (cur_state)
                  ST_I, ST_S: begin
                     getm = 1'b1;
                     miss = 1'b1;
                     ns   = ST_IM;
                  end
                  ST_O: begin
                     getm = 1'b1;
                     miss = 1'b1;
                     ns   = ST_OM;
                  end
                  ST_F: begin
                     getm = 1'b1;
                     miss = 1'b1;
                     ns   = ST_FM;
                  end
                  ST_M: tocpu = 1'b1;
                  ST_E: begin
                     tocpu = 1'b1;
                     upg   = 1'b1;
                     ns    = ST_M;
                  end
                  default: ;
               endcase
            end
            EV_GETS: begin
               case (cur_state)
                  ST_S, ST_MS: shr = 1'b1;
                  ST_O, ST_F, ST_OM, ST_FM: begin
                     tobus = 1'b1;
                     shr   = 1'b1;
                  end
                  ST_M: begin
                     tobus = 1'b1;
                     shr   = 1'b1;
                     ns    = ST_O;
                  end
                  ST_E: begin
                     tobus = 1'b1;
                     shr   = 1'b1;
                     ns    = ST_F;
                  end
                  default: ;
               endcase
            end
            EV_GETM: begin
               case (cur_state)
                  ST_S: ns = ST_I;
                  ST_O, ST_M, ST_E, ST_F: begin
                     tobus = 1'b1;
                     shr   = 1'b1;
                     ns    = ST_I;
                  end
                  ST_MS: begin
                     if (other) ns = ST_IM;
                  end
                  // OM gives up the line to any GETM, own or not
                  ST_OM: begin
                     tobus = 1'b1;
                     ns    = ST_IM;
                  end
                  ST_FM: begin
                     tobus = 1'b1;
                     if (other) ns = ST_IM;
                  end
                  default: ;
               endcase
            end
            default: begin
               case (cur_state)
                  ST_M: err = 1'b1;
                  ST_IS: begin
                     tocpu = 1'b1;
                     ns    = req.shared_in ? ST_S : ST_E;
                  end
                  ST_IM, ST_MS, ST_FM: begin
                     tocpu = 1'b1;
                     ns    = ST_M;
                  end
                  ST_OM: ns = ST_M;
                  default: ;
               endcase
            end
         endcase
      end

      // hold the state on an error
      if (err) ns = cur_state;

      rsp.issue_gets     = gets;
      rsp.issue_getm     = getm;
      rsp.data_to_cpu    = tocpu;
      rsp.data_to_bus    = tobus;
      rsp.data_dest      = tobus ? req.source_node : '0;
      rsp.out_addr       = (gets || getm || tocpu || tobus) ? req.line_addr : '0;
      rsp.assert_shared  = shr;
      rsp.miss_pulse     = miss;
      rsp.upgrade_pulse  = upg;
      rsp.protocol_error = err;
      rsp.new_state      = ns;
   end

endmodule

`default_nettype wire

// File: rtl/moesif_line_coherence_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Coherence controller for one cache line under a snooping MOESIF protocol.
// Each request word (processor load/store or snooped GETS/GETM/DATA) yields
// exactly one response word with the bus/processor actions and the new line
// state. Throughput is one word per cycle while rsp_ready does not stall the
// response register. A word is held in the request register, then the
// next-state lookup against the line state register fills the response
// register. The line state updates when a word moves into the response
// register. Write csr_write_data (own node id) only while the block is idle.

module moesif_line_coherence_controller
   import mlcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_write_en,
   input  wire logic [NodeWidth-1:0] csr_write_data,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_word_type         req_data,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_word_type              rsp_data
);

   logic [NodeWidth-1:0]  own_id_ff;
   logic [StateWidth-1:0] state_ff;
   logic                  in_vld_ff;
   req_word_type          in_word_ff;
   logic                  out_vld_ff;
   rsp_word_type          out_word_ff;

   rsp_word_type          out_word_in;
   logic                  adv;

   // advance the request word into the response register when it is free
   assign adv       = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;

   mlcc_next_state u_next_state (
      .cur_state   (state_ff),
      .own_node_id (own_id_ff),
      .req         (in_word_ff),
      .rsp         (out_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff  <= '0;
         state_ff   <= ST_I;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_write_en) own_id_ff <= csr_write_data;
         if (req_ready) in_vld_ff <= req_valid;
         if (adv) begin
            out_vld_ff <= 1'b1;
            state_ff   <= out_word_in.new_state;
         end else if (rsp_ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_word_ff <= req_data;
      if (adv) out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_word_ff;

   a_state_tracks_rsp: assert property (@(posedge clock) disable iff (reset)
      adv |=> state_ff == rsp_data.new_state)
      else $error("line state differs from reported new state");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      adv && out_word_in.protocol_error |=> state_ff == $past(state_ff))
      else $error("state changed on protocol error");

   a_state_legal: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_FM)
      else $error("line state out of range");

   a_upgrade_to_m: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.upgrade_pulse |->
         rsp_data.new_state == ST_M && rsp_data.data_to_cpu)
      else $error("upgrade without move to M");

endmodule

`default_nettype wire

// File: tb/sv/moesif_line_coherence_checker.sv
`timescale 1ns / 1ps

module moesif_line_coherence_checker
   import mlcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [NodeWidth-1:0] csr_write_data,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_word_type         req_data,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_word_type         rsp_data,
   output int                        fail_count,
   output int                        outstanding,
   output int                        compared_count
);

   rsp_word_type             awaited_actions[$];
   logic [StateWidth-1:0]    line_copy;
   logic [NodeWidth-1:0]     own_node_copy;
   int                       errors;
   int                       compared;

   initial begin
      errors = 0;
      compared = 0;
      fail_count = 0;
      outstanding = 0;
      compared_count = 0;
      line_copy = ST_I;
      own_node_copy = '0;
   end

   // Next-state lookup for one event; returns the response word and the new line state.
   function automatic rsp_word_type line_actions(
      input  logic [StateWidth-1:0] cur,
      input  logic [NodeWidth-1:0]  own,
      input  req_word_type          w,
      output logic [StateWidth-1:0] nxt
   );
      rsp_word_type r;
      logic         err;
      logic         other;
      r = '0;
      nxt = cur;
      err = 1'b0;
      other = (w.source_node != own);
      if (w.kind > EV_DATA || cur > ST_FM) begin
         err = 1'b1;
      end else begin
         case (w.kind)
            EV_LOAD: begin
               case (cur)
                  ST_I: begin
                     r.issue_gets = 1'b1;
                     r.miss_pulse = 1'b1;
                     nxt = ST_IS;
                  end
                  ST_S, ST_O, ST_M, ST_E, ST_F: r.data_to_cpu = 1'b1;
                  default: ;
               endcase
            end
            EV_STORE: begin
               case (cur)
                  ST_I, ST_S: begin
                     r.issue_getm = 1'b1;
                     r.miss_pulse = 1'b1;
                     nxt = ST_IM;
                  end
                  ST_O: begin
                     r.issue_getm = 1'b1;
                     r.miss_pulse = 1'b1;
                     nxt = ST_OM;
                  end
                  ST_F: begin
                     r.issue_getm = 1'b1;
                     r.miss_pulse = 1'b1;
                     nxt = ST_FM;
                  end
                  ST_M: r.data_to_cpu = 1'b1;
                  ST_E: begin
                     r.data_to_cpu = 1'b1;
                     r.upgrade_pulse = 1'b1;
                     nxt = ST_M;
                  end
                  default: ;
               endcase
            end
            EV_GETS: begin
               case (cur)
                  ST_S, ST_MS: r.assert_shared = 1'b1;
                  ST_O, ST_F, ST_OM, ST_FM: begin
                     r.data_to_bus = 1'b1;
                     r.assert_shared = 1'b1;
                  end
                  ST_M: begin
                     r.data_to_bus = 1'b1;
                     r.assert_shared = 1'b1;
                     nxt = ST_O;
                  end
                  ST_E: begin
                     r.data_to_bus = 1'b1;
                     r.assert_shared = 1'b1;
                     nxt = ST_F;
                  end
                  default: ;
               endcase
            end
            EV_GETM: begin
               case (cur)
                  ST_S: nxt = ST_I;
                  ST_O, ST_M, ST_E, ST_F: begin
                     r.data_to_bus = 1'b1;
                     r.assert_shared = 1'b1;
                     nxt = ST_I;
                  end
                  ST_MS: if (other) nxt = ST_IM;
                  // OM hands the line over no matter who asked
                  ST_OM: begin
                     r.data_to_bus = 1'b1;
                     nxt = ST_IM;
                  end
                  ST_FM: begin
                     r.data_to_bus = 1'b1;
                     if (other) nxt = ST_IM;
                  end
                  default: ;
               endcase
            end
            default: begin
               case (cur)
                  ST_M: err = 1'b1;
                  ST_IS: begin
                     r.data_to_cpu = 1'b1;
                     nxt = w.shared_in ? ST_S : ST_E;
                  end
                  ST_IM, ST_MS, ST_FM: begin
                     r.data_to_cpu = 1'b1;
                     nxt = ST_M;
                  end
                  ST_OM: nxt = ST_M;
                  default: ;
               endcase
            end
         endcase
      end
      if (err) nxt = cur;
      r.data_dest = r.data_to_bus ? w.source_node : '0;
      r.out_addr = (r.issue_gets | r.issue_getm | r.data_to_cpu | r.data_to_bus) ?
                   w.line_addr : '0;
      r.protocol_error = err;
      r.new_state = nxt;
      return r;
   endfunction

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors = errors + 1;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type           want;
      logic [StateWidth-1:0]  nxt;
      if (reset) begin
         awaited_actions.delete();
         line_copy = ST_I;
         own_node_copy = '0;
      end else begin
         if (csr_write_en) own_node_copy = csr_write_data;
         // pop before push: a word never comes back in the cycle it was taken
         if (rsp_valid && rsp_ready) begin
            if (awaited_actions.size() == 0) begin
               errors = errors + 1;
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = awaited_actions.pop_front();
               compared = compared + 1;
               check_field("issue_gets", 32'(want.issue_gets),
                           32'(rsp_data.issue_gets));
               check_field("issue_getm", 32'(want.issue_getm),
                           32'(rsp_data.issue_getm));
               check_field("data_to_cpu", 32'(want.data_to_cpu),
                           32'(rsp_data.data_to_cpu));
               check_field("data_to_bus", 32'(want.data_to_bus),
                           32'(rsp_data.data_to_bus));
               check_field("data_dest", 32'(want.data_dest),
                           32'(rsp_data.data_dest));
               check_field("out_addr", want.out_addr, rsp_data.out_addr);
               check_field("assert_shared", 32'(want.assert_shared),
                           32'(rsp_data.assert_shared));
               check_field("miss_pulse", 32'(want.miss_pulse),
                           32'(rsp_data.miss_pulse));
               check_field("upgrade_pulse", 32'(want.upgrade_pulse),
                           32'(rsp_data.upgrade_pulse));
               check_field("protocol_error", 32'(want.protocol_error),
                           32'(rsp_data.protocol_error));
               check_field("new_state", 32'(want.new_state),
                           32'(rsp_data.new_state));
            end
         end
         if (req_valid && req_ready) begin
            want = line_actions(line_copy, own_node_copy, req_data, nxt);
            line_copy = nxt;
            awaited_actions.push_back(want);
         end
      end
      outstanding <= awaited_actions.size();
      fail_count <= errors;
      compared_count <= compared;
   end

endmodule

// File: tb/sv/moesif_line_coherence_controller_tb.sv
`timescale 1ns / 1ps

module moesif_line_coherence_controller_tb;
   import mlcc_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [NodeWidth-1:0] csr_write_data;
   logic                 req_valid;
   logic                 req_ready;
   req_word_type         req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_word_type         rsp_data;

   int                   fail_count;
   int                   outstanding;
   int                   compared_count;

   logic [NodeWidth-1:0] cur_own;
   bit                   calm;
   int                   sent_count;
   int                   setting_count;

   moesif_line_coherence_controller dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

   moesif_line_coherence_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .compared_count (compared_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("moesif_line_coherence_controller_tb: errors");
      $finish;
   end

   // Response side: random ready/stall bursts, one long hold-off, steady at the end.
   initial begin : response_side
      int n;
      int cyc;
      bit held;
      cyc = 0;
      held = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && cyc >= 600) begin
            rsp_ready <= 1'b0;
            repeat (150) @(posedge clock);
            held = 1'b1;
            cyc = cyc + 150;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
            cyc = cyc + n;
         end else begin
            n = $urandom_range(1, 30);
            rsp_ready <= 1'b1;
            repeat (n) @(posedge clock);
            cyc = cyc + n;
         end
      end
   end

   // Offer one word and hold it until taken; returns at the accepting edge.
   task automatic send_word(input req_word_type w);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count = sent_count + 1;
   endtask

   task automatic send_event(input logic [KindWidth-1:0] kind, input logic [31:0] addr,
                             input logic [NodeWidth-1:0] src, input logic shr);
      req_word_type w;
      w.kind = kind;
      w.line_addr = addr;
      w.source_node = src;
      w.shared_in = shr;
      send_word(w);
   endtask

   task automatic send_random(input logic [KindWidth-1:0] kind);
      send_event(kind, $urandom, NodeWidth'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)));
   endtask

   // Snooped request from this node about a third of the time, any node otherwise.
   function automatic logic [NodeWidth-1:0] pick_source();
      if ($urandom_range(0, 2) == 0) return cur_own;
      return NodeWidth'($urandom_range(0, 15));
   endfunction

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_own_id(input logic [NodeWidth-1:0] id);
      drain_all();
      repeat (3) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= id;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_own = id;
      setting_count = setting_count + 1;
   endtask

   // One short bus transaction with random content, or a stray word.
   task automatic run_sequence();
      case ($urandom_range(0, 9))
         0, 1: begin
            send_random(EV_LOAD);
            send_random(EV_DATA);
         end
         2, 3: begin
            send_random(EV_STORE);
            send_random(EV_DATA);
         end
         4: send_event(EV_GETS, $urandom, pick_source(), 1'($urandom_range(0, 1)));
         5: send_event(EV_GETM, $urandom, pick_source(), 1'($urandom_range(0, 1)));
         6: begin
            send_random(EV_STORE);
            send_event(EV_GETM, $urandom, pick_source(), 1'($urandom_range(0, 1)));
            send_random(EV_DATA);
         end
         7: begin
            send_random(EV_LOAD);
            send_random(EV_DATA);
            send_event(EV_GETS, $urandom, pick_source(), 1'($urandom_range(0, 1)));
            send_random(EV_STORE);
         end
         8: send_random(KindWidth'($urandom_range(0, 1)));
         default: send_random(KindWidth'($urandom_range(0, 7)));
      endcase
   endtask

   initial begin : stimulus
      logic [NodeWidth-1:0] ids[5];
      int phase;
      int goal;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_data <= '0;
      cur_own = '0;
      calm = 1'b0;
      sent_count = 0;
      setting_count = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through every state reachable from I, node id 0
      send_event(EV_LOAD, 32'h0000_0000, 4'd0, 1'b0);
      send_event(EV_STORE, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_event(EV_LOAD, 32'h1234_5678, 4'd3, 1'b0);
      send_event(EV_DATA, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_event(EV_GETS, 32'h8000_0001, 4'd15, 1'b0);
      send_event(EV_STORE, 32'hA5A5_A5A5, 4'd0, 1'b0);
      send_event(EV_GETM, 32'h5A5A_5A5A, 4'd0, 1'b0);
      send_event(EV_DATA, 32'h0000_0001, 4'd1, 1'b0);
      send_event(EV_DATA, 32'hFFFF_FFFE, 4'd2, 1'b1);
      send_event(3'd5, 32'hDEAD_BEEF, 4'd4, 1'b1);
      send_event(3'd7, 32'hFFFF_FFFF, 4'd15, 1'b1);
      send_event(EV_GETS, 32'h0F0F_0F0F, 4'd15, 1'b0);
      send_event(EV_STORE, 32'hF0F0_F0F0, 4'd8, 1'b0);
      send_event(EV_LOAD, 32'h1111_1111, 4'd8, 1'b0);
      send_event(EV_GETS, 32'h2222_2222, 4'd6, 1'b1);
      send_event(EV_GETM, 32'h3333_3333, 4'd0, 1'b0);
      send_event(EV_DATA, 32'h4444_4444, 4'd5, 1'b0);
      send_event(EV_GETM, 32'h5555_5555, 4'd9, 1'b0);
      send_event(EV_LOAD, 32'h6666_6666, 4'd0, 1'b0);
      send_event(EV_DATA, 32'h7777_7777, 4'd0, 1'b0);
      send_event(EV_GETS, 32'h8888_8888, 4'd12, 1'b0);
      send_event(EV_LOAD, 32'h9999_9999, 4'd0, 1'b0);
      send_event(EV_STORE, 32'hAAAA_AAAA, 4'd0, 1'b0);
      send_event(EV_GETM, 32'hBBBB_BBBB, 4'd0, 1'b0);
      send_event(EV_GETM, 32'hCCCC_CCCC, 4'd3, 1'b0);
      send_event(EV_DATA, 32'hDDDD_DDDD, 4'd0, 1'b0);
      send_event(EV_GETM, 32'hEEEE_EEEE, 4'd7, 1'b0);

      ids[0] = 4'd15;
      ids[1] = 4'd0;
      ids[2] = NodeWidth'($urandom_range(1, 14));
      ids[3] = 4'd15;
      ids[4] = NodeWidth'($urandom_range(0, 15));
      for (phase = 0; phase < 5; phase++) begin
         write_own_id(ids[phase]);
         if (phase == 4) calm = 1'b1;
         goal = sent_count + 340;
         while (sent_count < goal) run_sequence();
      end

      drain_all();
      repeat (8) @(posedge clock);
      $display("covered %0d request words under %0d node-id settings: state walk, random",
               sent_count, setting_count);
      $display("bus transactions, stray kinds and own-node snoops; %0d responses compared",
               compared_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("moesif_line_coherence_controller_tb: clean");
      end else begin
         $display("moesif_line_coherence_controller_tb: errors");
      end
      $finish;
   end

endmodule
